// ===== hdl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;

    // Field widths
    localparam int RAW_W     = 24;
    localparam int COEFF_W   = 16;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;
    localparam int DT_W      = 25;
    localparam int PROD_W    = 42;
    localparam int DTSQ_W    = 50;
    localparam int T2_W      = 17;
    localparam int OFS_W     = 36;
    localparam int SQ_W      = 37;
    localparam int CORR_W    = 41;
    localparam int FIN_W     = 42;
    localparam int HALF_W    = 21;
    localparam int PLO_W     = 45;
    localparam int PHI_W     = 46;
    localparam int MUL_W     = 66;
    localparam int Q1_W      = 45;
    localparam int X_W       = 46;
    localparam int CFG_IDX_W = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

    // Temperature thresholds relative to 20.00 degC
    localparam logic signed [TEMP_W-1:0]   COLD_OFS = 19'sd3500;
    localparam logic signed [TEMP_W:0]     TEMP_REF = 20'sd2000;

    // Calibration coefficients
    typedef struct packed {
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] offset;
        logic [COEFF_W-1:0] sens_temp;
        logic [COEFF_W-1:0] offset_temp;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
    } t_coeffs;

    // One classified word handed from front to back
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] a;      // temperature minus 20.00 degC
        logic signed [TEMP_W-1:0] b;      // temperature plus 15.00 degC
        logic [T2_W-1:0]          t2;
        logic signed [OFS_W-1:0]  off;
        logic signed [OFS_W-1:0]  sens;
        logic                     low;    // below 20.00 degC
        logic                     cold;   // below -15.00 degC
    } t_item;

endpackage

// ===== hdl/baro_pressure_compensation.sv =====
// Top level of the barometric pressure compensation block.
//
// Usage:
//   Write the six calibration coefficients through i_cfg_we / i_cfg_index /
//   i_cfg_data while no word is in flight; indexes above five are ignored.
//   Input words (raw pressure and raw temperature) are taken when i_in_valid
//   is high and o_in_stall is low. Each word yields exactly one result word,
//   compensated temperature and pressure, shown with o_out_valid and taken
//   when i_out_stall is low.
//   Throughput: one word per cycle while nothing stalls; the front pipeline,
//   the four-word queue and the back pipeline each hold one word a stage.
//   A stalled output word holds steady; the back pipeline freezes, the queue
//   fills, and then the front raises o_in_stall.
//   Reset (i_rst_n low, synchronous) clears all coefficients to zero,
//   empties the queue and drops every word in flight.
module baro_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEFF_W-1:0]       i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [RAW_W-1:0]         i_pressure_raw,
    input  logic [RAW_W-1:0]         i_temperature_raw,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic signed [PRES_W-1:0] o_pressure_centi_mbar
);

    t_coeffs r_coeffs;
    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_item   w_push_item;
    t_item   w_pop_item;

    // Write calibration coefficients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SENS:        r_coeffs.sens        <= i_cfg_data;
                REG_OFFSET:      r_coeffs.offset      <= i_cfg_data;
                REG_SENS_TEMP:   r_coeffs.sens_temp   <= i_cfg_data;
                REG_OFFSET_TEMP: r_coeffs.offset_temp <= i_cfg_data;
                REG_REF_TEMP:    r_coeffs.ref_temp    <= i_cfg_data;
                REG_TEMP_SLOPE:  r_coeffs.temp_slope  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_coeffs          (r_coeffs),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pressure_raw    (i_pressure_raw),
        .i_temperature_raw (i_temperature_raw),
        .o_push            (w_push),
        .o_item            (w_push_item),
        .i_full            (w_full)
    );

    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_empty (w_empty)
    );

    bpc_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_empty               (w_empty),
        .i_item                (w_pop_item),
        .o_pop                 (w_pop),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar)
    );

endmodule

// ===== hdl/bpc_queue.sv =====
// Short word queue between the front and back parts.
module bpc_queue
    import bpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item              r_mem [QUEUE_DEPTH];
    t_item              r_head;
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_item   = r_head;
    assign n_rd_ptr = i_pop ? (r_rd_ptr + QPTR_W'(1)) : r_rd_ptr;

    // Store pushed word and fetch the word at the next read position;
    // a word pushed into the slot about to be read goes straight to the head
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_item;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            r_rd_ptr <= n_rd_ptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/bpc_front.sv =====
// Front part: accept raw words, compute first-order terms and classify.
module bpc_front
    import bpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_coeffs          i_coeffs,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [RAW_W-1:0] i_pressure_raw,
    input  logic [RAW_W-1:0] i_temperature_raw,
    output logic             o_push,
    output t_item            o_item,
    input  logic             i_full
);

    logic                     w_en;

    logic                     r_f1_valid;
    logic [RAW_W-1:0]         r_f1_d1;
    logic signed [DT_W-1:0]   r_f1_dt;
    logic signed [DT_W-1:0]   n_f1_dt;

    logic                     r_f2_valid;
    logic [RAW_W-1:0]         r_f2_d1;
    logic signed [PROD_W-1:0] r_f2_pt;
    logic signed [PROD_W-1:0] r_f2_c4;
    logic signed [PROD_W-1:0] r_f2_c3;
    logic [DTSQ_W-1:0]        r_f2_sq;
    logic signed [DTSQ_W-1:0] w_sq;

    logic                     r_f3_valid;
    t_item                    r_f3_item;
    t_item                    n_f3_item;

    logic signed [PROD_W-1:0] w_pt_adj;
    logic signed [PROD_W-1:0] w_c4_adj;
    logic signed [PROD_W-1:0] w_c3_adj;
    logic signed [TEMP_W-1:0] w_q;

    // Stall everything when the last stage cannot hand its word on
    assign w_en       = !(r_f3_valid && i_full);
    assign o_in_stall = !w_en;
    assign o_push     = r_f3_valid && !i_full;
    assign o_item     = r_f3_item;

    // Difference to reference temperature
    assign n_f1_dt = $signed({1'b0, i_temperature_raw})
                   - $signed({1'b0, i_coeffs.ref_temp, 8'h00});

    assign w_sq = r_f1_dt * r_f1_dt;

    // Truncate the scaled products toward zero and build the word
    always_comb begin
        w_pt_adj = r_f2_pt + (r_f2_pt[PROD_W-1] ? 42'sd8388607 : 42'sd0);
        w_c4_adj = r_f2_c4 + (r_f2_c4[PROD_W-1] ? 42'sd127 : 42'sd0);
        w_c3_adj = r_f2_c3 + (r_f2_c3[PROD_W-1] ? 42'sd255 : 42'sd0);
        w_q      = w_pt_adj[PROD_W-1:23];

        n_f3_item.d1   = r_f2_d1;
        n_f3_item.a    = w_q;
        n_f3_item.b    = w_q + COLD_OFS;
        n_f3_item.t2   = r_f2_sq[47:31];
        n_f3_item.off  = $signed({4'b0, i_coeffs.offset, 16'h0000})
                       + $signed({w_c4_adj[PROD_W-1], w_c4_adj[PROD_W-1:7]});
        n_f3_item.sens = $signed({5'b0, i_coeffs.sens, 15'h0000})
                       + $signed({{2{w_c3_adj[PROD_W-1]}}, w_c3_adj[PROD_W-1:8]});
        n_f3_item.low  = w_q[TEMP_W-1];
        n_f3_item.cold = n_f3_item.b[TEMP_W-1];
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (w_en) begin
            r_f1_valid <= i_in_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_d1   <= i_pressure_raw;
            r_f1_dt   <= n_f1_dt;
            r_f2_d1   <= r_f1_d1;
            r_f2_pt   <= r_f1_dt * $signed({1'b0, i_coeffs.temp_slope});
            r_f2_c4   <= r_f1_dt * $signed({1'b0, i_coeffs.offset_temp});
            r_f2_c3   <= r_f1_dt * $signed({1'b0, i_coeffs.sens_temp});
            r_f2_sq   <= w_sq;
            r_f3_item <= n_f3_item;
        end
    end

endmodule

// ===== hdl/bpc_back.sv =====
// Back part: second-order correction, pressure product and output register.
module bpc_back
    import bpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  t_item                    i_item,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic signed [PRES_W-1:0] o_pressure_centi_mbar
);

    localparam int NSTAGE = 8;

    logic                      w_en;
    logic [NSTAGE-1:0]         r_valid;

    // Stage 1: squares
    logic [RAW_W-1:0]          r_b1_d1;
    logic signed [TEMP_W-1:0]  r_b1_a;
    logic [T2_W-1:0]           r_b1_t2;
    logic signed [OFS_W-1:0]   r_b1_off;
    logic signed [OFS_W-1:0]   r_b1_sens;
    logic [SQ_W-1:0]           r_b1_asq;
    logic [SQ_W-1:0]           r_b1_bsq;
    logic signed [SQ_W:0]      w_asq;
    logic signed [SQ_W:0]      w_bsq;

    // Stage 2: offset and sensitivity corrections
    logic [RAW_W-1:0]          r_b2_d1;
    logic signed [TEMP_W-1:0]  r_b2_a;
    logic [T2_W-1:0]           r_b2_t2;
    logic signed [OFS_W-1:0]   r_b2_off;
    logic signed [OFS_W-1:0]   r_b2_sens;
    logic [CORR_W-1:0]         r_b2_off2;
    logic [CORR_W-1:0]         r_b2_sens2;
    logic [CORR_W-1:0]         w_five_a;
    logic [CORR_W-1:0]         w_seven_b;
    logic [CORR_W-1:0]         w_eleven_b;

    // Stage 3: corrected terms and temperature
    logic [RAW_W-1:0]          r_b3_d1;
    logic signed [FIN_W-1:0]   r_b3_off;
    logic signed [FIN_W-1:0]   r_b3_sens;
    logic signed [TEMP_W-1:0]  r_b3_temp;
    logic signed [TEMP_W:0]    w_temp;
    logic signed [TEMP_W-1:0]  n_b3_temp;

    // Stage 4: partial products of raw pressure and sensitivity
    logic signed [FIN_W-1:0]   r_b4_off;
    logic signed [TEMP_W-1:0]  r_b4_temp;
    logic [PLO_W-1:0]          r_b4_plo;
    logic signed [PHI_W-1:0]   r_b4_phi;

    // Stage 5: full product
    logic signed [FIN_W-1:0]   r_b5_off;
    logic signed [TEMP_W-1:0]  r_b5_temp;
    logic signed [MUL_W-1:0]   r_b5_prod;
    logic signed [MUL_W-1:0]   w_prod;

    // Stage 6: product scaled down
    logic signed [FIN_W-1:0]   r_b6_off;
    logic signed [TEMP_W-1:0]  r_b6_temp;
    logic signed [Q1_W-1:0]    r_b6_q1;
    logic signed [MUL_W-1:0]   w_prod_adj;

    // Stage 7: offset removed
    logic signed [TEMP_W-1:0]  r_b7_temp;
    logic signed [X_W-1:0]     r_b7_x;

    // Output register
    logic signed [TEMP_W-1:0]  r_out_temp;
    logic signed [PRES_W-1:0]  r_out_pres;
    logic signed [X_W-1:0]     w_x_adj;

    // Freeze the whole back part while the output word waits
    assign w_en        = !(r_valid[NSTAGE-1] && i_out_stall);
    assign o_pop       = w_en && !i_empty;
    assign o_out_valid = r_valid[NSTAGE-1];
    assign o_temperature_centi   = r_out_temp;
    assign o_pressure_centi_mbar = r_out_pres;

    assign w_asq = i_item.a * i_item.a;
    assign w_bsq = i_item.b * i_item.b;

    // Scale squares by five, seven and eleven
    always_comb begin
        w_five_a   = {2'b0, r_b1_asq, 2'b0} + {4'b0, r_b1_asq};
        w_seven_b  = {1'b0, r_b1_bsq, 3'b0} - {4'b0, r_b1_bsq};
        w_eleven_b = {1'b0, r_b1_bsq, 3'b0} + {3'b0, r_b1_bsq, 1'b0}
                   + {4'b0, r_b1_bsq};
    end

    // Apply second-order temperature and saturate to the field range
    always_comb begin
        w_temp = {r_b2_a[TEMP_W-1], r_b2_a} + TEMP_REF
               - $signed({{(TEMP_W + 1 - T2_W){1'b0}}, r_b2_t2});
        if (w_temp[TEMP_W] != w_temp[TEMP_W-1]) begin
            n_b3_temp = w_temp[TEMP_W] ? {1'b1, {(TEMP_W-1){1'b0}}}
                                       : {1'b0, {(TEMP_W-1){1'b1}}};
        end else begin
            n_b3_temp = w_temp[TEMP_W-1:0];
        end
    end

    // Recombine partial products and truncate toward zero
    always_comb begin
        w_prod     = ($signed({{(MUL_W-PHI_W){r_b4_phi[PHI_W-1]}}, r_b4_phi}) <<< HALF_W)
                   + $signed({{(MUL_W-PLO_W){1'b0}}, r_b4_plo});
        w_prod_adj = r_b5_prod + (r_b5_prod[MUL_W-1] ? 66'sd2097151 : 66'sd0);
        w_x_adj    = r_b7_x + (r_b7_x[X_W-1] ? 46'sd32767 : 46'sd0);
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NSTAGE-2:0], o_pop};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_d1    <= i_item.d1;
            r_b1_a     <= i_item.a;
            r_b1_t2    <= i_item.low ? i_item.t2 : '0;
            r_b1_off   <= i_item.off;
            r_b1_sens  <= i_item.sens;
            r_b1_asq   <= i_item.low ? w_asq[SQ_W-1:0] : '0;
            r_b1_bsq   <= (i_item.low && i_item.cold) ? w_bsq[SQ_W-1:0] : '0;

            r_b2_d1    <= r_b1_d1;
            r_b2_a     <= r_b1_a;
            r_b2_t2    <= r_b1_t2;
            r_b2_off   <= r_b1_off;
            r_b2_sens  <= r_b1_sens;
            r_b2_off2  <= (w_five_a >> 1) + w_seven_b;
            r_b2_sens2 <= (w_five_a >> 2) + (w_eleven_b >> 1);

            r_b3_d1    <= r_b2_d1;
            r_b3_off   <= {{(FIN_W-OFS_W){r_b2_off[OFS_W-1]}}, r_b2_off}
                        - $signed({1'b0, r_b2_off2});
            r_b3_sens  <= {{(FIN_W-OFS_W){r_b2_sens[OFS_W-1]}}, r_b2_sens}
                        - $signed({1'b0, r_b2_sens2});
            r_b3_temp  <= n_b3_temp;

            r_b4_off   <= r_b3_off;
            r_b4_temp  <= r_b3_temp;
            r_b4_plo   <= r_b3_d1 * r_b3_sens[HALF_W-1:0];
            r_b4_phi   <= $signed({1'b0, r_b3_d1}) * $signed(r_b3_sens[FIN_W-1:HALF_W]);

            r_b5_off   <= r_b4_off;
            r_b5_temp  <= r_b4_temp;
            r_b5_prod  <= w_prod;

            r_b6_off   <= r_b5_off;
            r_b6_temp  <= r_b5_temp;
            r_b6_q1    <= w_prod_adj[MUL_W-1:HALF_W];

            r_b7_temp  <= r_b6_temp;
            r_b7_x     <= {r_b6_q1[Q1_W-1], r_b6_q1}
                        - {{(X_W-FIN_W){r_b6_off[FIN_W-1]}}, r_b6_off};

            r_out_temp <= r_b7_temp;
            r_out_pres <= {w_x_adj[X_W-1], w_x_adj[45:15]};
        end
    end

endmodule

// ===== tb/tb_baro_pressure_compensation.sv =====
// Testbench for the barometric pressure compensation block: directed and random words.
`timescale 1ns / 1ps

module tb_baro_pressure_compensation;
    import bpc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int LATENCY      = 11;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 170;
    localparam int HOLD_WORDS   = 40;
    localparam int RAW_MAX      = 24'hFFFFFF;

    // Indexes past the last coefficient; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Temperature limits of the output field
    localparam longint TEMP_FLOOR = -262144;
    localparam longint TEMP_CEIL  = 262143;
    localparam longint DTSQ_DIV   = 64'sd2147483648;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idling;

    typedef struct {
        logic [RAW_W-1:0]         d1;
        logic [RAW_W-1:0]         d2;
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } t_reading;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [COEFF_W-1:0]       i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [RAW_W-1:0]         i_pressure_raw = '0;
    logic [RAW_W-1:0]         i_temperature_raw = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature_centi;
    logic signed [PRES_W-1:0] o_pressure_centi_mbar;

    t_coeffs  cal = '0;
    t_reading expected_readings[$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_budget = 0;
    int       quiet_cycles = 0;

    baro_pressure_compensation u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_pressure_raw        (i_pressure_raw),
        .i_temperature_raw     (i_temperature_raw),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Compute compensated temperature and pressure for one raw pair
    function automatic t_reading compensate(input t_coeffs k, input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint d1, d2, dt, temp, off, sens, t2, off2, sens2, a, b, p;
        t_reading r;
        d1    = longint'(d1_raw);
        d2    = longint'(d2_raw);
        dt    = d2 - longint'(k.ref_temp) * 256;
        temp  = 2000 + (dt * longint'(k.temp_slope)) / 8388608;
        off   = longint'(k.offset) * 65536 + (longint'(k.offset_temp) * dt) / 128;
        sens  = longint'(k.sens) * 32768 + (longint'(k.sens_temp) * dt) / 256;
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        // Second-order correction below 20 degC, extra term below -15 degC
        if (temp < 2000) begin
            a     = temp - 2000;
            t2    = (dt * dt) / DTSQ_DIV;
            off2  = (5 * a * a) / 2;
            sens2 = (5 * a * a) / 4;
            if (temp < -1500) begin
                b     = temp + 1500;
                off2  = off2 + 7 * b * b;
                sens2 = sens2 + (11 * b * b) / 2;
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = ((d1 * sens) / 2097152 - off) / 32768;
        // Saturate temperature, wrap pressure
        if (temp < TEMP_FLOOR) temp = TEMP_FLOOR;
        if (temp > TEMP_CEIL) temp = TEMP_CEIL;
        r.d1   = d1_raw;
        r.d2   = d2_raw;
        r.temp = temp[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Check each accepted result word against the oldest pending reading
    always @(posedge i_clk) begin : check_result
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("result word with no input word pending");
            end else begin
                want = expected_readings.pop_front();
                if (o_temperature_centi !== want.temp)
                    report_mismatch($sformatf("d1=%0d d2=%0d temperature got %0d want %0d",
                        want.d1, want.d2, o_temperature_centi, want.temp));
                if (o_pressure_centi_mbar !== want.pres)
                    report_mismatch($sformatf("d1=%0d d2=%0d pressure got %0d want %0d",
                        want.d1, want.d2, o_pressure_centi_mbar, want.pres));
            end
        end
    end

    // Drive receiver stall: a long hold-off when requested, random otherwise
    always @(posedge i_clk) begin
        if (hold_budget > 0) begin
            i_out_stall <= 1'b1;
            hold_budget--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic set_idling(input t_idling mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 59 : (mode == IDLE_BOTH) ? 35 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 59 : (mode == IDLE_BOTH) ? 35 : 0;
    endtask

    // Offer one word, hold it until accepted, then record its expected reading
    task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_pressure_raw    <= d1;
        i_temperature_raw <= d2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_readings.push_back(compensate(cal, d1, d2));
    endtask

    // Drop valid and wait until every pending result has arrived
    task automatic wait_drained(input int pad);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_SENS:        cal.sens        = data;
            REG_OFFSET:      cal.offset      = data;
            REG_SENS_TEMP:   cal.sens_temp   = data;
            REG_OFFSET_TEMP: cal.offset_temp = data;
            REG_REF_TEMP:    cal.ref_temp    = data;
            REG_TEMP_SLOPE:  cal.temp_slope  = data;
            default: ;
        endcase
    endtask

    task automatic program_coeffs(input t_coeffs k);
        wait_drained(4);
        write_reg(REG_SENS, k.sens);
        write_reg(REG_OFFSET, k.offset);
        write_reg(REG_SENS_TEMP, k.sens_temp);
        write_reg(REG_OFFSET_TEMP, k.offset_temp);
        write_reg(REG_REF_TEMP, k.ref_temp);
        write_reg(REG_TEMP_SLOPE, k.temp_slope);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // Raw temperature: full range half the time, else near the reference point
    function automatic logic [RAW_W-1:0] pick_temp_raw();
        int d2;
        if ($urandom_range(0, 1) == 0) return RAW_W'($urandom);
        d2 = int'(cal.ref_temp) * 256 + int'($urandom_range(0, 4194304)) - 2097152;
        if (d2 < 0) d2 = 0;
        if (d2 > RAW_MAX) d2 = RAW_MAX;
        return RAW_W'(d2);
    endfunction

    function automatic logic [RAW_W-1:0] pick_pres_raw();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Coefficients are all zero out of reset
    task automatic test_reset_coeffs();
        set_idling(IDLE_NONE);
        send_word('0, '0);
        send_word('1, '1);
        send_word(24'd9085466, 24'd8569150);
    endtask

    // Writes to indexes past the last coefficient leave the calibration as is
    task automatic test_spare_index();
        program_coeffs('{sens: 16'd40127, offset: 16'd36924, sens_temp: 16'd23317,
                         offset_temp: 16'd23282, ref_temp: 16'd33464, temp_slope: 16'd28312});
        wait_drained(4);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        i_cfg_we <= 1'b0;
        send_word(24'd9085466, 24'd8569150);
        send_word('1, '0);
    endtask

    // Hot, exactly 20 degC, just below, cool, cold and raw extremes
    task automatic test_temperature_bands();
        set_idling(IDLE_SEND);
        send_word(24'd9085466, 24'd10000000);
        send_word(24'd9085466, 24'd8566784);
        send_word(24'd9085466, 24'd8566783);
        send_word(24'd9085466, 24'd7600000);
        send_word(24'd9085466, 24'd7529784);
        send_word(24'd9085466, 24'd7000000);
        send_word('0, '0);
        send_word('1, '0);
        send_word('0, '1);
        send_word('1, '1);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'hAAAAAA, 24'h555555);
    endtask

    // All coefficients at their maximum
    task automatic test_max_coeffs();
        program_coeffs('1);
        set_idling(IDLE_RECV);
        send_word('0, '0);
        send_word('1, '0);
        send_word('0, '1);
        send_word('1, '1);
    endtask

    // Random words across calibrations and idling patterns
    task automatic test_random_phases();
        t_coeffs k;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                k = '0;
            else if (ph == 1)
                k = '1;
            else
                k = '{sens: pick_coeff(), offset: pick_coeff(), sens_temp: pick_coeff(),
                      offset_temp: pick_coeff(), ref_temp: pick_coeff(),
                      temp_slope: pick_coeff()};
            program_coeffs(k);
            set_idling(t_idling'(ph % 4));
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(pick_pres_raw(), pick_temp_raw());
        end
    endtask

    // Hold the receiver off while words keep coming, so the input stalls
    task automatic test_stall_holdoff();
        program_coeffs('{sens: 16'd40127, offset: 16'd36924, sens_temp: 16'd23317,
                         offset_temp: 16'd23282, ref_temp: 16'd33464, temp_slope: 16'd28312});
        set_idling(IDLE_NONE);
        hold_budget = HOLD_CYCLES;
        for (int n = 0; n < HOLD_WORDS; n++)
            send_word(pick_pres_raw(), pick_temp_raw());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_coeffs();
        test_spare_index();
        test_temperature_bands();
        test_max_coeffs();
        test_random_phases();
        test_stall_holdoff();
        set_idling(IDLE_NONE);
        wait_drained(2 * LATENCY);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== baro_pressure_compensation.f =====
hdl/bpc_pkg.sv
hdl/bpc_queue.sv
hdl/bpc_front.sv
hdl/bpc_back.sv
hdl/baro_pressure_compensation.sv
tb/tb_baro_pressure_compensation.sv
